// File: rtl/rbi_pkg.sv
`timescale 1ns / 1ps

package rbi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DIR_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DIR_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_DIR_Z = 3'd5;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // Load enables of the two register stages of a fixed-point multiplier.
    typedef struct packed {
        logic mul;
        logic sat;
    } mul_en_t;

endpackage

// File: rtl/rbi_fx_mul.sv
`timescale 1ns / 1ps

module rbi_fx_mul
    import rbi_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int FB = FRAC_BITS_DEF,
    parameter int AW = COORD_WIDTH_DEF
)
(
    input  logic                 clk,
    input  mul_en_t              en,
    input  logic signed [AW-1:0] a,
    input  logic signed [CW-1:0] b,
    output logic signed [CW-1:0] q
);

    localparam int PW = AW + CW;

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] shifted;
    logic        [PW-CW:0] upper;
    logic signed [CW-1:0] q_reg;
    logic signed [CW-1:0] q_next;

    assign prod_next = PW'(a) * PW'(b);

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            prod_reg <= prod_next;
        end
    end

    // An arithmetic shift of the full product rounds toward minus infinity.
    always_comb
    begin
        shifted = prod_reg >>> FB;
        upper   = shifted[PW-1:CW-1];
        if ((&upper) || (~|upper))
        begin
            q_next = shifted[CW-1:0];
        end
        else if (shifted[PW-1])
        begin
            q_next = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            q_next = {1'b0, {(CW-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.sat)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// File: rtl/rbi_axis_pick.sv
`timescale 1ns / 1ps

module rbi_axis_pick
    import rbi_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF
)
(
    input  logic signed [CW-1:0] tv_x,
    input  logic signed [CW-1:0] tv_y,
    input  logic signed [CW-1:0] tv_z,
    output axis_t                ax_b,
    output axis_t                ax_c,
    output logic signed [CW-1:0] t
);

    axis_t ax;

    // A strictly greater distance is needed to keep an earlier axis.
    always_comb
    begin
        if (tv_x > tv_y)
        begin
            ax = (tv_x > tv_z) ? AXIS_X : AXIS_Z;
        end
        else
        begin
            ax = (tv_y > tv_z) ? AXIS_Y : AXIS_Z;
        end

        case (ax)
            AXIS_X:
            begin
                ax_b = AXIS_Y;
                ax_c = AXIS_Z;
                t    = tv_x;
            end
            AXIS_Y:
            begin
                ax_b = AXIS_Z;
                ax_c = AXIS_X;
                t    = tv_y;
            end
            default:
            begin
                ax_b = AXIS_X;
                ax_c = AXIS_Y;
                t    = tv_z;
            end
        endcase
    end

endmodule

// File: rtl/ray_box_intersect_top.sv
`timescale 1ns / 1ps

// Ray versus axis-aligned box slab test, signed fixed point.
// Each accepted input beat passes through every stage below, ending in the output register on the master side.
// Throughput: one box per cycle while m_tready allows; each pipeline stage has its own valid bit and
// stalls only when the stage after it is full and not moving.
// Reset clears all valid bits and the six direction registers to zero.

module ray_box_intersect_top
    import rbi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [COORD_WIDTH-1:0]          cfg_data,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // origin_x, origin_y, origin_z, best_t; zero padded to whole bytes
    input  logic [((10*COORD_WIDTH+7)/8)*8-1:0] s_tdata,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // hit, new_best_t; zero padded to whole bytes
    output logic [((COORD_WIDTH+8)/8)*8-1:0] m_tdata
);

    localparam int CW    = COORD_WIDTH;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [CW:0]   diff_t;

    typedef struct packed {
        coord_t [2:0] bmin;
        coord_t [2:0] bmax;
        coord_t [2:0] org;
        coord_t       best;
        logic         org_in_box;
    } box_ctx_t;

    typedef struct packed {
        coord_t t;
        coord_t best;
        logic   too_far;
        logic   org_in_box;
        coord_t org_b;
        coord_t org_c;
        coord_t lo_b;
        coord_t hi_b;
        coord_t lo_c;
        coord_t hi_c;
    } hit_ctx_t;

    // Configuration registers.
    coord_t dir_reg [3];
    coord_t inv_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dir_reg[i] <= '0;
                inv_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DIR_X:     dir_reg[0] <= cfg_data;
                REG_DIR_Y:     dir_reg[1] <= cfg_data;
                REG_DIR_Z:     dir_reg[2] <= cfg_data;
                REG_INV_DIR_X: inv_reg[0] <= cfg_data;
                REG_INV_DIR_Y: inv_reg[1] <= cfg_data;
                REG_INV_DIR_Z: inv_reg[2] <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its successor moves.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, out_valid_reg;
    logic en1, en2, en3, en4, en5, en6, en7, en8;

    assign en8 = !out_valid_reg || m_tready;
    assign en7 = !v7_reg || en8;
    assign en6 = !v6_reg || en7;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg        <= s_tvalid;
            if (en2) v2_reg        <= v1_reg;
            if (en3) v3_reg        <= v2_reg;
            if (en4) v4_reg        <= v3_reg;
            if (en5) v5_reg        <= v4_reg;
            if (en6) v6_reg        <= v5_reg;
            if (en7) v7_reg        <= v6_reg;
            if (en8) out_valid_reg <= v7_reg;
        end
    end

    // Stage 1: slab differences and the test whether the origin lies in the box.
    coord_t   in_bmin [3];
    coord_t   in_bmax [3];
    coord_t   in_org  [3];
    coord_t   near_v  [3];
    diff_t    diff_next [3];
    diff_t    s1_diff_reg [3];
    box_ctx_t s1_ctx_next;
    box_ctx_t s1_ctx_reg;
    box_ctx_t s2_ctx_reg;
    box_ctx_t s3_ctx_reg;

    always_comb
    begin
        s1_ctx_next.org_in_box = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            in_bmin[i] = s_tdata[i*CW +: CW];
            in_bmax[i] = s_tdata[(3+i)*CW +: CW];
            in_org[i]  = s_tdata[(6+i)*CW +: CW];
            near_v[i]  = dir_reg[i][CW-1] ? in_bmax[i] : in_bmin[i];
            diff_next[i] = diff_t'(near_v[i]) - diff_t'(in_org[i]);
            s1_ctx_next.bmin[i] = in_bmin[i];
            s1_ctx_next.bmax[i] = in_bmax[i];
            s1_ctx_next.org[i]  = in_org[i];
            if ((in_org[i] < in_bmin[i]) || (in_org[i] > in_bmax[i]))
            begin
                s1_ctx_next.org_in_box = 1'b0;
            end
        end
        s1_ctx_next.best = s_tdata[9*CW +: CW];
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_diff_reg <= diff_next;
            s1_ctx_reg  <= s1_ctx_next;
        end
        if (en2) s2_ctx_reg <= s1_ctx_reg;
        if (en3) s3_ctx_reg <= s2_ctx_reg;
    end

    // Stages 2 and 3: slab distances.
    mul_en_t slab_en;
    coord_t  tv [3];

    assign slab_en.mul = en2;
    assign slab_en.sat = en3;

    for (genvar g = 0; g < 3; g++)
    begin : g_slab
        rbi_fx_mul #(
            .CW (CW),
            .FB (FRAC_BITS),
            .AW (CW + 1)
        ) u_slab_mul (
            .clk (clk),
            .en  (slab_en),
            .a   (s1_diff_reg[g]),
            .b   (inv_reg[g]),
            .q   (tv[g])
        );
    end

    // Stage 4: pick the entry axis and gather the other two axes.
    axis_t    ax_b, ax_c;
    coord_t   t_pick;
    hit_ctx_t s4_ctx_next;
    hit_ctx_t s4_ctx_reg;
    hit_ctx_t s5_ctx_reg;
    hit_ctx_t s6_ctx_reg;
    coord_t   s4_dir_b_reg;
    coord_t   s4_dir_c_reg;

    rbi_axis_pick #(
        .CW (CW)
    ) u_axis_pick (
        .tv_x (tv[0]),
        .tv_y (tv[1]),
        .tv_z (tv[2]),
        .ax_b (ax_b),
        .ax_c (ax_c),
        .t    (t_pick)
    );

    always_comb
    begin
        s4_ctx_next.t          = t_pick;
        s4_ctx_next.best       = s3_ctx_reg.best;
        s4_ctx_next.too_far    = t_pick > $signed(s3_ctx_reg.best);
        s4_ctx_next.org_in_box = s3_ctx_reg.org_in_box;
        s4_ctx_next.org_b      = s3_ctx_reg.org[ax_b];
        s4_ctx_next.org_c      = s3_ctx_reg.org[ax_c];
        s4_ctx_next.lo_b       = s3_ctx_reg.bmin[ax_b];
        s4_ctx_next.hi_b       = s3_ctx_reg.bmax[ax_b];
        s4_ctx_next.lo_c       = s3_ctx_reg.bmin[ax_c];
        s4_ctx_next.hi_c       = s3_ctx_reg.bmax[ax_c];
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_ctx_reg   <= s4_ctx_next;
            s4_dir_b_reg <= dir_reg[ax_b];
            s4_dir_c_reg <= dir_reg[ax_c];
        end
        if (en5) s5_ctx_reg <= s4_ctx_reg;
        if (en6) s6_ctx_reg <= s5_ctx_reg;
    end

    // Stages 5 and 6: offsets of the hit point along the other two axes.
    mul_en_t pt_en;
    coord_t  off_b, off_c;

    assign pt_en.mul = en5;
    assign pt_en.sat = en6;

    rbi_fx_mul #(
        .CW (CW),
        .FB (FRAC_BITS),
        .AW (CW)
    ) u_pt_mul_b (
        .clk (clk),
        .en  (pt_en),
        .a   (s4_ctx_reg.t),
        .b   (s4_dir_b_reg),
        .q   (off_b)
    );

    rbi_fx_mul #(
        .CW (CW),
        .FB (FRAC_BITS),
        .AW (CW)
    ) u_pt_mul_c (
        .clk (clk),
        .en  (pt_en),
        .a   (s4_ctx_reg.t),
        .b   (s4_dir_c_reg),
        .q   (off_c)
    );

    // Stage 7: hit point coordinates, saturated.
    diff_t    sum_b, sum_c;
    coord_t   pb_next, pc_next;
    coord_t   s7_pb_reg, s7_pc_reg;
    hit_ctx_t s7_ctx_reg;

    localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};

    always_comb
    begin
        sum_b = diff_t'(coord_t'(s6_ctx_reg.org_b)) + diff_t'(off_b);
        sum_c = diff_t'(coord_t'(s6_ctx_reg.org_c)) + diff_t'(off_c);
        if (sum_b[CW] != sum_b[CW-1])
        begin
            pb_next = sum_b[CW] ? C_MIN : C_MAX;
        end
        else
        begin
            pb_next = sum_b[CW-1:0];
        end
        if (sum_c[CW] != sum_c[CW-1])
        begin
            pc_next = sum_c[CW] ? C_MIN : C_MAX;
        end
        else
        begin
            pc_next = sum_c[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en7)
        begin
            s7_pb_reg  <= pb_next;
            s7_pc_reg  <= pc_next;
            s7_ctx_reg <= s6_ctx_reg;
        end
    end

    // Stage 8: final decision into the output register.
    logic   hit_next;
    logic   out_hit_reg;
    coord_t out_t_reg;

    always_comb
    begin
        hit_next = !s7_ctx_reg.too_far;
        if ((s7_pb_reg < $signed(s7_ctx_reg.lo_b)) || (s7_pb_reg > $signed(s7_ctx_reg.hi_b)))
        begin
            hit_next = 1'b0;
        end
        if ((s7_pc_reg < $signed(s7_ctx_reg.lo_c)) || (s7_pc_reg > $signed(s7_ctx_reg.hi_c)))
        begin
            hit_next = 1'b0;
        end
        // A box behind the origin counts only when the origin sits inside it.
        if (s7_ctx_reg.t[CW-1] && !s7_ctx_reg.org_in_box)
        begin
            hit_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en8)
        begin
            out_hit_reg <= hit_next;
            out_t_reg   <= hit_next ? s7_ctx_reg.t : s7_ctx_reg.best;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        m_tdata       = '0;
        m_tdata[0]    = out_hit_reg;
        m_tdata[CW:1] = out_t_reg;
    end

    // The pipeline always takes a beat when the output register is free.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty output register");

    // A candidate beyond the best distance never comes out as a hit.
    a_far_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (v7_reg && en8 && s7_ctx_reg.too_far) |=> !out_hit_reg)
        else $error("candidate beyond best_t reported as a hit");

    // The chosen distance is one of the three slab distances.
    a_pick_is_slab: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && en4) |=> ((s4_ctx_reg.t == $past(tv[0])) ||
                             (s4_ctx_reg.t == $past(tv[1])) ||
                             (s4_ctx_reg.t == $past(tv[2]))))
        else $error("entry distance does not match any slab distance");

endmodule

// File: tb/rbi_checker.sv
`timescale 1ns / 1ps

module rbi_checker
    import rbi_pkg::*;
#(
    parameter int W = COORD_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [W-1:0]                cfg_data,

    input  logic                        s_tvalid,
    input  logic                        s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // origin_x, origin_y, origin_z, best_t
    input  logic [((10*W+7)/8)*8-1:0]   s_tdata,

    input  logic                        m_tvalid,
    input  logic                        m_tready,
    // hit, new_best_t
    input  logic [((W+8)/8)*8-1:0]      m_tdata,

    output int                          fail_count,
    output int                          pending
);

    localparam int SW = ((10*W+7)/8)*8;

    localparam logic signed [2*W+1:0] PROD_MAX = {{(W+3){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [2*W+1:0] PROD_MIN = ~PROD_MAX;
    localparam logic signed [W+1:0]   SUM_MAX  = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0]   SUM_MIN  = ~SUM_MAX;

    typedef struct packed {
        logic         hit;
        logic [W-1:0] new_t;
    } hit_result_t;

    hit_result_t hit_q [$];

    logic signed [W-1:0] ray_dir [3];
    logic signed [W-1:0] ray_inv [3];

    // Product shifted down by the fraction width, rounded toward minus infinity,
    // then clamped to the coordinate range.
    function automatic logic signed [W-1:0] fx_mul(input logic signed [W:0] a,
                                                   input logic signed [W-1:0] b);
        logic signed [2*W+1:0] p;
        p = a * b;
        p = p >>> F;
        if (p > PROD_MAX)
            return PROD_MAX[W-1:0];
        if (p < PROD_MIN)
            return PROD_MIN[W-1:0];
        return p[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W+1:0] s;
        s = a + b;
        if (s > SUM_MAX)
            return SUM_MAX[W-1:0];
        if (s < SUM_MIN)
            return SUM_MIN[W-1:0];
        return s[W-1:0];
    endfunction

    function automatic hit_result_t slab_test(input logic [SW-1:0] beat);
        logic signed [W-1:0] lo [3];
        logic signed [W-1:0] hi [3];
        logic signed [W-1:0] org [3];
        logic signed [W-1:0] slab_d [3];
        logic signed [W-1:0] best, t, near, pa, pb;
        logic signed [W:0]   span, t_wide;
        logic                hit;
        axis_t               ax;
        int                  a2, a3, i;
        hit_result_t         res;
        for (i = 0; i < 3; i++)
        begin
            lo[i]  = beat[i*W +: W];
            hi[i]  = beat[(3+i)*W +: W];
            org[i] = beat[(6+i)*W +: W];
            near   = (ray_dir[i] >= 0) ? lo[i] : hi[i];
            span   = near - org[i];
            slab_d[i] = fx_mul(span, ray_inv[i]);
        end
        best = beat[9*W +: W];

        // The earlier axis needs a strictly larger distance to win.
        if (slab_d[0] > slab_d[1])
            ax = (slab_d[0] > slab_d[2]) ? AXIS_X : AXIS_Z;
        else
            ax = (slab_d[1] > slab_d[2]) ? AXIS_Y : AXIS_Z;
        t = slab_d[ax];
        t_wide = t;
        a2 = (int'(ax) + 1) % 3;
        a3 = (a2 + 1) % 3;

        hit = 1'b1;
        if (t > best)
            hit = 1'b0;
        else
        begin
            pa = sat_add(org[a2], fx_mul(t_wide, ray_dir[a2]));
            pb = sat_add(org[a3], fx_mul(t_wide, ray_dir[a3]));
            if (pa < lo[a2] || pa > hi[a2])
                hit = 1'b0;
            if (pb < lo[a3] || pb > hi[a3])
                hit = 1'b0;
            // A box behind the origin only counts when the origin sits inside it.
            if (hit && t < 0)
                for (i = 0; i < 3; i++)
                    if (org[i] < lo[i] || org[i] > hi[i])
                        hit = 1'b0;
        end
        res.hit   = hit;
        res.new_t = hit ? t : best;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ray_dir[i] <= '0;
                ray_inv[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DIR_X:     ray_dir[0] <= cfg_data;
                REG_DIR_Y:     ray_dir[1] <= cfg_data;
                REG_DIR_Z:     ray_dir[2] <= cfg_data;
                REG_INV_DIR_X: ray_inv[0] <= cfg_data;
                REG_INV_DIR_Y: ray_inv[1] <= cfg_data;
                REG_INV_DIR_Z: ray_inv[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin : compare_blk
        hit_result_t got, want;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                hit_q.push_back(slab_test(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got.hit   = m_tdata[0];
                got.new_t = m_tdata[W:1];
                if (hit_q.size() == 0)
                begin
                    $error("result beat with no box waiting: hit %0d new_best_t %h",
                           got.hit, got.new_t);
                    errs++;
                end
                else
                begin
                    want = hit_q.pop_front();
                    if (got.hit !== want.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                        errs++;
                    end
                    if (got.new_t !== want.new_t)
                    begin
                        $error("new_best_t: expected %h, actual %h", want.new_t, got.new_t);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending    <= hit_q.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import rbi_pkg::*;

    localparam int W  = COORD_WIDTH_DEF;
    localparam int F  = FRAC_BITS_DEF;
    localparam int SW = ((10*W+7)/8)*8;
    localparam int MW = ((W+8)/8)*8;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int ITEMS_PER_MODE = 150;

    // Indexes the block does not decode; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam logic signed [W-1:0] Q_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] Q_MIN = {1'b1, {(W-1){1'b0}}};

    // Field positions within one box beat.
    localparam int MIN0 = 0;
    localparam int MAX0 = 3;
    localparam int ORG0 = 6;
    localparam int BEST = 9;

    typedef logic [9:0][W-1:0] box_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [W-1:0]         cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [SW-1:0]        s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [MW-1:0]        m_tdata;

    int fail_count;
    int pending;
    int snd_idle = 0;
    int rcv_idle = 0;
    int stall_cycles = 0;

    logic signed [W-1:0] ray_dir [3];

    ray_box_intersect_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    rbi_checker #(.W(W), .F(F)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rcv_idle);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic logic signed [W-1:0] q(input int units);
        return W'(units) <<< F;
    endfunction

    function automatic logic signed [W-1:0] recip(input logic signed [W-1:0] d);
        longint r;
        if (d == 0)
            return Q_MAX;
        r = (longint'(1) <<< (2*F)) / longint'(d);
        if (r > Q_MAX)
            return Q_MAX;
        if (r < Q_MIN)
            return Q_MIN;
        return W'(r);
    endfunction

    function automatic box_t unit_box(input int nx, ny, nz, xx, xy, xz, ox, oy, oz,
                                      input logic signed [W-1:0] best);
        box_t b;
        b[MIN0]   = q(nx);
        b[MIN0+1] = q(ny);
        b[MIN0+2] = q(nz);
        b[MAX0]   = q(xx);
        b[MAX0+1] = q(xy);
        b[MAX0+2] = q(xz);
        b[ORG0]   = q(ox);
        b[ORG0+1] = q(oy);
        b[ORG0+2] = q(oz);
        b[BEST]   = best;
        return b;
    endfunction

    // Mostly boxes placed around a point of the current ray, so that hits,
    // near misses and distance rejections all occur; some raw noise.
    function automatic box_t random_box();
        box_t   b;
        int     r, a;
        longint s, org, p, h, tmp;
        r = $urandom_range(99);
        if (r < 15)
        begin
            for (a = 0; a < 10; a++)
                b[a] = $urandom;
            return b;
        end
        s = longint'($urandom_range(0, 32 << F)) - (8 << F);
        if (r < 25)
            s = 0;
        for (a = 0; a < 3; a++)
        begin
            org = longint'($urandom_range(0, 128 << F)) - (64 << F);
            p   = org + ((s * longint'(ray_dir[a])) >>> F);
            h   = longint'($urandom_range(0, 4 << F));
            b[ORG0+a] = W'(org);
            b[MIN0+a] = W'(p - h);
            b[MAX0+a] = W'(p + h);
            if (r < 19 && a == int'(r % 3))
            begin
                tmp = b[MIN0+a];
                b[MIN0+a] = b[MAX0+a];
                b[MAX0+a] = W'(tmp);
            end
        end
        case ($urandom_range(9))
            0, 1, 2, 3: b[BEST] = Q_MAX;
            4, 5, 6, 7: b[BEST] = W'(longint'($urandom_range(0, 64 << F)) - (32 << F));
            default:    b[BEST] = W'(s + longint'($urandom_range(0, 2 << F)) - (1 << F));
        endcase
        return b;
    endfunction

    task automatic push_box(input box_t b);
        while ($urandom_range(99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= SW'(b);
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    task automatic set_ray(input logic signed [W-1:0] dx, dy, dz, ix, iy, iz,
                           input logic spare);
        wait_results();
        if (spare)
        begin
            cfg_write(REG_SPARE_A, $urandom);
            cfg_write(REG_SPARE_B, $urandom);
        end
        cfg_write(REG_DIR_X, dx);
        cfg_write(REG_DIR_Y, dy);
        cfg_write(REG_DIR_Z, dz);
        cfg_write(REG_INV_DIR_X, ix);
        cfg_write(REG_INV_DIR_Y, iy);
        cfg_write(REG_INV_DIR_Z, iz);
        cfg_wr_en <= 1'b0;
        ray_dir[0] = dx;
        ray_dir[1] = dy;
        ray_dir[2] = dz;
    endtask

    task automatic new_random_ray();
        logic signed [W-1:0] d [3];
        int a;
        if ($urandom_range(4) == 0)
        begin
            set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    1'($urandom_range(1)));
            return;
        end
        for (a = 0; a < 3; a++)
            d[a] = ($urandom_range(3) == 0) ? '0
                   : W'(int'($urandom_range(0, 8 << F)) - (4 << F));
        set_ray(d[0], d[1], d[2], recip(d[0]), recip(d[1]), recip(d[2]),
                $urandom_range(3) == 0);
    endtask

    initial
    begin
        int sent, n, m;
        ray_dir[0] = '0;
        ray_dir[1] = '0;
        ray_dir[2] = '0;
        snd_idle = 16;
        rcv_idle = 74;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers still at reset: every slab distance is zero.
        push_box(unit_box(-1, -1, -1, 1, 1, 1, 0, 0, 0, Q_MAX));
        push_box(unit_box(2, -1, -1, 3, 1, 1, 0, 0, 0, Q_MAX));

        // Direction (1, 0.5, -0.25): the z slab uses the box maximum.
        set_ray(q(1), q(1) >>> 1, -(q(1) >>> 2), q(1), q(2), q(-4), 1'b0);
        push_box(unit_box(4, 1, -2, 6, 4, 0, 0, 0, 0, Q_MAX));
        push_box(unit_box(4, 1, -2, 6, 4, 0, 0, 0, 0, q(3)));
        push_box(unit_box(4, 1, -2, 6, 4, 0, 0, 0, 0, q(4)));
        push_box(unit_box(-1, -1, -1, 1, 1, 1, 0, 0, 0, Q_MAX));
        push_box(unit_box(-6, -3, 0, -4, -1, 2, 0, 0, 0, Q_MAX));
        push_box(unit_box(4, 10, -2, 6, 12, 0, 0, 0, 0, Q_MAX));
        push_box(unit_box(6, 1, -2, 4, 4, 0, 0, 0, 0, Q_MAX));
        push_box({10{Q_MIN}});
        push_box({10{Q_MAX}});
        push_box({Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN});

        // Equal distances on several axes; the later axis must win.
        set_ray(q(1), q(1), q(1), q(1), q(1), q(1), 1'b1);
        push_box(unit_box(-1, -1, -1, 1, 1, 1, -5, -5, -5, Q_MAX));
        push_box(unit_box(-1, -2, -1, 1, 2, 1, -5, -5, -5, Q_MAX));
        push_box(unit_box(-1, -1, -2, 1, 1, 2, -5, -5, -5, Q_MAX));

        // Zero x direction with a saturated reciprocal.
        set_ray('0, q(1), q(-1), Q_MAX, q(1), q(-1), 1'b0);
        push_box(unit_box(-1, 2, -3, 1, 3, -2, 0, 0, 0, Q_MAX));
        push_box(unit_box(1, 2, -3, 2, 3, -2, 0, 0, 0, Q_MAX));

        // Register extremes drive products into saturation.
        set_ray(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0);
        push_box(unit_box(-1, -1, -1, 1, 1, 1, 3, -2, 0, Q_MAX));
        push_box({Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN});
        set_ray(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b0);
        push_box(unit_box(-1, -1, -1, 1, 1, 1, -3, 2, 0, Q_MAX));
        push_box({10{Q_MIN}});

        for (m = 0; m < 3; m++)
        begin
            case (m)
                0:
                begin
                    snd_idle = 16;
                    rcv_idle = 74;
                end
                1:
                begin
                    snd_idle = 74;
                    rcv_idle = 16;
                end
                default:
                begin
                    snd_idle = 0;
                    rcv_idle = 0;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_MODE)
            begin
                new_random_ray();
                n = $urandom_range(4, 24);
                repeat (n) push_box(random_box());
                sent += n;
            end
        end

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
